@@ rtl/core/sorted_ring_priority_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// sorted ring priority queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SORTED_RING_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_RING_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define SRPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srpq check failed");

// next-cycle implication
`define SRPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srpq check failed");

`endif

@@ rtl/core/srpq_pkg.sv @@
// ----------------------------------------------------------------------------
// srpq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package srpq_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int KEY_WIDTH_DEF   = 16;

    localparam int KEY_FIELD_W     = 16;
    localparam int COUNT_FIELD_W   = 6;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 32;

    localparam int FRONT_KEY_LSB   = 0;
    localparam int FRONT_VALID_BIT = 16;
    localparam int COUNT_LSB       = 17;
    localparam int FULL_BIT        = 23;
    localparam int REJECTED_BIT    = 24;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } srpq_func_t;

    typedef struct packed {
        logic push;
        logic pop;
    } srpq_cmd_t;

endpackage

@@ rtl/core/srpq_cell.sv @@
// ----------------------------------------------------------------------------
// srpq_cell
// one slot of the sorted chain: keeps, takes the new key or shifts a neighbor
// ----------------------------------------------------------------------------
module srpq_cell
    import srpq_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srpq_cmd_t            cmd,
    input  logic [KEY_WIDTH-1:0] new_key,
    input  logic                 prev_lt,
    input  logic [KEY_WIDTH-1:0] prev_key,
    input  logic                 prev_valid,
    input  logic [KEY_WIDTH-1:0] next_key,
    input  logic                 next_valid,
    output logic                 lt,
    output logic [KEY_WIDTH-1:0] key,
    output logic                 valid,
    output logic [KEY_WIDTH-1:0] key_next,
    output logic                 valid_next
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic                 valid_reg;

    assign lt    = valid_reg && (key_reg < new_key);
    assign key   = key_reg;
    assign valid = valid_reg;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (cmd.push)
        begin
            if (!lt)
            begin
                if (prev_lt)
                begin
                    key_next   = new_key;
                    valid_next = 1'b1;
                end
                else
                begin
                    key_next   = prev_key;
                    valid_next = prev_valid;
                end
            end
        end
        else if (cmd.pop)
        begin
            key_next   = next_key;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.push || cmd.pop)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.pop)
        begin
            key_reg <= key_next;
        end
    end

endmodule

@@ rtl/core/sorted_ring_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_ring_priority_queue_core
// sorted priority queue built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// s_axis carries one operation per item: tuser is func (0 push, 1 pop) and
// tdata is the key to push. m_axis returns one item per operation with the
// queue state after it: front key, front valid, count, full and rejected.
// every cell compares its key with the new key in parallel and keeps it,
// takes the new key or takes its neighbor's key, so a push or a pop updates
// all cells at once whatever the fill level.
// the result item is valid the cycle after the operation item is
// accepted. throughput: one item per cycle while m_axis takes results.
// the output register sits between the two sides; a new item is accepted
// while the held result is taken in the same cycle.
// if m_axis stalls, the result is held and s_axis_tready drops until the
// result is taken.
// reset empties the queue (all cell valid bits clear, count zero); no
// clearing pass is needed before the first item is taken.
// ----------------------------------------------------------------------------
module sorted_ring_priority_queue_core
    import srpq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // key[15:0]
    input  logic                 s_axis_tuser,   // func[0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // front_key[15:0], front_valid[16],
                                                 // count[22:17], full_res[23],
                                                 // rejected[24], zero[31:25]
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 in_fire;
    srpq_cmd_t            cmd;
    logic [KEY_WIDTH-1:0] new_key;
    logic                 is_full;
    logic                 is_empty;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic [KEY_WIDTH-1:0]     cell_key   [DEPTH];
    logic [DEPTH-1:0]         cell_valid;
    logic [DEPTH-1:0]         cell_lt;
    logic [KEY_WIDTH-1:0]     cell_key_next [DEPTH];
    logic [DEPTH-1:0]         cell_valid_next;

    logic [KEY_WIDTH-1:0]     front_raw;
    logic [KEY_FIELD_W-1:0]   front_key;
    logic [COUNT_FIELD_W-1:0] count_field;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_full       = (count_reg == CNT_W'(DEPTH));
    assign is_empty      = (count_reg == '0);

    assign cmd.push = in_fire && (s_axis_tuser == FUNC_PUSH) && !is_full;
    assign cmd.pop  = in_fire && (s_axis_tuser == FUNC_POP) && !is_empty;

    // key width adaptation
    generate
        if (KEY_WIDTH > KEY_FIELD_W)
        begin : g_key_wide
            assign new_key   = {{(KEY_WIDTH - KEY_FIELD_W){1'b0}}, s_axis_tdata};
            assign front_key = front_raw[KEY_FIELD_W-1:0];
        end
        else if (KEY_WIDTH == KEY_FIELD_W)
        begin : g_key_same
            assign new_key   = s_axis_tdata;
            assign front_key = front_raw;
        end
        else
        begin : g_key_narrow
            assign new_key   = s_axis_tdata[KEY_WIDTH-1:0];
            assign front_key = {{(KEY_FIELD_W - KEY_WIDTH){1'b0}}, front_raw};
        end
    endgenerate

    // count width adaptation
    generate
        if (CNT_W > COUNT_FIELD_W)
        begin : g_cnt_wide
            assign count_field = count_next[COUNT_FIELD_W-1:0];
        end
        else if (CNT_W == COUNT_FIELD_W)
        begin : g_cnt_same
            assign count_field = count_next;
        end
        else
        begin : g_cnt_narrow
            assign count_field = {{(COUNT_FIELD_W - CNT_W){1'b0}}, count_next};
        end
    endgenerate

    // cell chain, cell 0 holds the smallest key
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                 prev_lt;
            logic [KEY_WIDTH-1:0] prev_key;
            logic                 prev_valid;
            logic [KEY_WIDTH-1:0] next_key;
            logic                 next_valid;

            if (i == 0)
            begin : g_first
                assign prev_lt    = 1'b1;
                assign prev_key   = '0;
                assign prev_valid = 1'b0;
            end
            else
            begin : g_mid
                assign prev_lt    = cell_lt[i-1];
                assign prev_key   = cell_key[i-1];
                assign prev_valid = cell_valid[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_key   = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_key   = cell_key[i+1];
                assign next_valid = cell_valid[i+1];
            end

            srpq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .new_key    (new_key),
                .prev_lt    (prev_lt),
                .prev_key   (prev_key),
                .prev_valid (prev_valid),
                .next_key   (next_key),
                .next_valid (next_valid),
                .lt         (cell_lt[i]),
                .key        (cell_key[i]),
                .valid      (cell_valid[i]),
                .key_next   (cell_key_next[i]),
                .valid_next (cell_valid_next[i])
            );
        end
    endgenerate

    assign front_raw = cell_valid_next[0] ? cell_key_next[0] : '0;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[FRONT_KEY_LSB +: KEY_FIELD_W]  = front_key;
        out_data_next[FRONT_VALID_BIT]               = cell_valid_next[0];
        out_data_next[COUNT_LSB +: COUNT_FIELD_W]    = count_field;
        out_data_next[FULL_BIT]                      = (count_next == CNT_W'(DEPTH));
        out_data_next[REJECTED_BIT]                  = !(cmd.push || cmd.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ rtl/core/srpq_checker.sv @@
// ----------------------------------------------------------------------------
// srpq_checker
// port-level checks of the sorted priority queue, bound to the core module
// ----------------------------------------------------------------------------
`include "sorted_ring_priority_queue_core_macros.svh"

module srpq_checker
    import srpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [COUNT_FIELD_W-1:0] DEPTH_FIELD = COUNT_FIELD_W'(DEPTH);

    logic [COUNT_FIELD_W-1:0] count_field;

    assign count_field = m_axis_tdata[COUNT_LSB +: COUNT_FIELD_W];

    `SRPQ_ASSERT_NEXT(a_result_follows, clk, rst_n,
        s_axis_tvalid && s_axis_tready, m_axis_tvalid)

    `SRPQ_ASSERT_NEXT(a_result_held, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    `SRPQ_ASSERT_IMPLY(a_front_matches_count, clk, rst_n,
        m_axis_tvalid, m_axis_tdata[FRONT_VALID_BIT] == (count_field != '0))

    `SRPQ_ASSERT_IMPLY(a_full_matches_count, clk, rst_n,
        m_axis_tvalid, m_axis_tdata[FULL_BIT] == (count_field == DEPTH_FIELD))

endmodule

bind sorted_ring_priority_queue_core srpq_checker #(
    .DEPTH (DEPTH)
) u_srpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
